/* rtl/time_weighted_moving_average_core_defines.svh */
// Assertion macros used by the checker file of the moving average core.
// Depends on nothing; the using scope must provide clk_i and rst_ni.
`ifndef TIME_WEIGHTED_MOVING_AVERAGE_CORE_DEFINES_SVH
`define TIME_WEIGHTED_MOVING_AVERAGE_CORE_DEFINES_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define TWMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define TWMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/twma_pkg.sv */
// Shared constants for the duration-weighted moving average core.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps
package twma_pkg;

  // Request kinds carried in tuser
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;
  localparam logic [1:0] CFG_SPAN   = 2'd2;

  localparam logic [31:0] WINDOW_RESET = 32'd600000;

  // Field widths
  localparam int VAL_W = 32;
  localparam int DUR_W = 24;
  localparam int AVG_W = 40;
  localparam int PCT_W = 7;
  localparam int CNT_W = 9;
  localparam int FRAC_W = 8;
  localparam int WS_W  = 64;

  localparam int PCT_SCALE = 100;

  // Result word bit positions
  localparam int OUT_PCT_LSB    = AVG_W;
  localparam int OUT_CNT_LSB    = OUT_PCT_LSB + PCT_W;
  localparam int OUT_TAKEN_BIT  = OUT_CNT_LSB + CNT_W;
  localparam int OUT_FORCED_BIT = OUT_TAKEN_BIT + 1;

endpackage

/* rtl/time_weighted_moving_average_core.sv */
// Duration-weighted moving average over a ring of samples.
// An add request (tuser[0] = 0) brings a signed sample and its duration;
// a clear request (tuser[0] = 1) empties the ring and keeps the last average.
// Input tdata: sample_value [31:0], duration_ms [55:32].
// Output tdata: average_q8 [39:0], higher_percent [46:40], entry_count [55:47],
//   sample_taken [56], oldest_forced_out [57], zero fill above.
// Registers are written on the cfg channel (index 0 window, 1 threshold,
// 2 span); cfg_ready_o is always high.
// One request at a time: s_axis_tready is high only while the sequencer idles.
// An add occupies the core from its accept to the next accept: it appends the
// sample (a full ring first forces out its oldest entry), evicts the oldest
// entries while the duration sum exceeds the window, divides for the average,
// walks the entries for the percentage and divides again, paced by the single
// ring read port and the shared one-bit-per-cycle divider; the result shows as
// tready rises. A clear skips to the result, a zero-duration add to the walk.
// Reset empties the ring and the sums; no clearing pass is needed.
// A stalled result waits in the output register; the next request finishes
// its work and holds until that register is free.
`timescale 1ns / 1ps
module time_weighted_moving_average_core #(
  parameter int DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // sample_value, duration_ms
  input  logic [0:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // average_q8, higher_percent, entry_count,
                                      // sample_taken, oldest_forced_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DTW   = twma_pkg::DUR_W + AW + 1;
  localparam int PW    = twma_pkg::VAL_W + twma_pkg::DUR_W + 1;
  localparam int NUM_W = twma_pkg::WS_W + twma_pkg::FRAC_W;
  localparam int HPW   = CW + twma_pkg::PCT_W;
  localparam int KW    = $clog2(NUM_W);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_APPEND   = 4'd1;
  localparam logic [3:0] S_ADDACC   = 4'd2;
  localparam logic [3:0] S_EVCHK    = 4'd3;
  localparam logic [3:0] S_DROP_RD  = 4'd4;
  localparam logic [3:0] S_DROP_MUL = 4'd5;
  localparam logic [3:0] S_DROP_SUB = 4'd6;
  localparam logic [3:0] S_AVG_DIV  = 4'd7;
  localparam logic [3:0] S_PCT_INIT = 4'd8;
  localparam logic [3:0] S_PCT_RD   = 4'd9;
  localparam logic [3:0] S_PCT_ACC  = 4'd10;
  localparam logic [3:0] S_PCT_DIV  = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  // Ring storage
  logic signed [twma_pkg::VAL_W-1:0] val_mem [DEPTH];
  logic [twma_pkg::DUR_W-1:0]        dur_mem [DEPTH];
  logic signed [twma_pkg::VAL_W-1:0] rd_val_q;
  logic [twma_pkg::DUR_W-1:0]        rd_dur_q;
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr, mem_raddr;

  logic [3:0]                        state_q, state_d;
  logic [AW-1:0]                     oldest_q, oldest_d, idx_q, idx_d;
  logic [CW-1:0]                     held_q, held_d, hits_q, hits_d, seen_q, seen_d;
  logic signed [twma_pkg::WS_W-1:0]  ws_q, ws_d;
  logic [DTW-1:0]                    dt_q, dt_d, span_q, span_d;
  logic [twma_pkg::AVG_W-1:0]        avg_q, avg_d;
  logic signed [PW-1:0]              prod_q, prod_d;
  logic signed [twma_pkg::VAL_W-1:0] val_q, val_d;
  logic [twma_pkg::DUR_W-1:0]        dur_q, dur_d;
  logic                              taken_q, taken_d, forced_q, forced_d;
  logic                              fdrop_q, fdrop_d, neg_q, neg_d;
  logic [31:0]                       window_q, thr_q, spancfg_q;
  logic [DTW-1:0]                    rem_q, rem_d, den_q, den_d;
  logic [NUM_W-1:0]                  num_q, num_d;
  logic [twma_pkg::AVG_W-1:0]        quo_q, quo_d;
  logic [KW-1:0]                     cnt_q, cnt_d;
  logic [twma_pkg::PCT_W-1:0]        pct_q, pct_d;
  logic                              out_valid_q, out_valid_d;
  logic [63:0]                       out_data_q, out_data_d;

  // Divider step, ring arithmetic and walk terms
  logic [DTW:0]                      rem_sh;
  logic                              div_ge;
  logic [DTW-1:0]                    rem_nx;
  logic [twma_pkg::AVG_W-1:0]        quo_nx;
  logic                              div_last;
  logic [AW:0]                       slot_sum, newest_sum;
  logic [AW-1:0]                     slot_idx, newest_idx, oldest_inc, idx_dec;
  logic [DTW-1:0]                    span_n;
  logic [CW-1:0]                     seen_n, hits_n;
  logic [HPW-1:0]                    hits_pct;
  logic [twma_pkg::WS_W-1:0]         ws_mag;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign rem_sh   = {rem_q, num_q[NUM_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, den_q});
  assign rem_nx   = div_ge ? DTW'(rem_sh - {1'b0, den_q}) : rem_sh[DTW-1:0];
  assign quo_nx   = {quo_q[twma_pkg::AVG_W-2:0], div_ge};
  assign div_last = (cnt_q == KW'(NUM_W - 1));

  assign slot_sum   = {1'b0, oldest_q} + (AW+1)'(held_q);
  assign slot_idx   = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                   : slot_sum[AW-1:0];
  assign newest_sum = slot_sum - (AW+1)'(1);
  assign newest_idx = (newest_sum >= (AW+1)'(DEPTH)) ? AW'(newest_sum - (AW+1)'(DEPTH))
                                                     : newest_sum[AW-1:0];
  assign oldest_inc = (oldest_q == AW'(DEPTH - 1)) ? '0 : AW'(oldest_q + AW'(1));
  assign idx_dec    = (idx_q == '0) ? AW'(DEPTH - 1) : AW'(idx_q - AW'(1));

  assign span_n   = span_q + DTW'(rd_dur_q);
  assign seen_n   = seen_q + CW'(1);
  assign hits_n   = (rd_val_q > $signed(thr_q)) ? CW'(hits_q + CW'(1)) : hits_q;
  assign hits_pct = HPW'(hits_n) * HPW'(twma_pkg::PCT_SCALE);
  assign ws_mag   = ws_q[twma_pkg::WS_W-1] ? twma_pkg::WS_W'(-ws_q) : ws_q;

  // Sequence one request
  always_comb begin
    state_d    = state_q;
    oldest_d   = oldest_q;
    idx_d      = idx_q;
    held_d     = held_q;
    hits_d     = hits_q;
    seen_d     = seen_q;
    ws_d       = ws_q;
    dt_d       = dt_q;
    span_d     = span_q;
    avg_d      = avg_q;
    prod_d     = prod_q;
    val_d      = val_q;
    dur_d      = dur_q;
    taken_d    = taken_q;
    forced_d   = forced_q;
    fdrop_d    = fdrop_q;
    neg_d      = neg_q;
    rem_d      = rem_q;
    den_d      = den_q;
    num_d      = num_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    pct_d      = pct_q;
    mem_we     = 1'b0;
    mem_waddr  = slot_idx;
    mem_raddr  = oldest_q;
    out_data_d = out_data_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          taken_d  = 1'b0;
          forced_d = 1'b0;
          val_d    = s_axis_tdata[twma_pkg::VAL_W-1:0];
          dur_d    = s_axis_tdata[twma_pkg::VAL_W +: twma_pkg::DUR_W];
          if (s_axis_tuser[0] == twma_pkg::OP_CLEAR) begin
            held_d   = '0;
            oldest_d = '0;
            ws_d     = '0;
            dt_d     = '0;
            pct_d    = '0;
            state_d  = S_DONE;
          end else if (s_axis_tdata[twma_pkg::VAL_W +: twma_pkg::DUR_W] == '0) begin
            state_d = S_PCT_INIT;
          end else begin
            taken_d = 1'b1;
            if (held_q >= CW'(DEPTH)) begin
              forced_d = 1'b1;
              fdrop_d  = 1'b1;
              state_d  = S_DROP_RD;
            end else begin
              state_d = S_APPEND;
            end
          end
        end
      end
      S_APPEND: begin
        mem_we  = 1'b1;
        prod_d  = PW'(val_q * $signed({1'b0, dur_q}));
        held_d  = held_q + CW'(1);
        dt_d    = dt_q + DTW'(dur_q);
        state_d = S_ADDACC;
      end
      S_ADDACC: begin
        ws_d    = ws_q + twma_pkg::WS_W'(prod_q);
        state_d = S_EVCHK;
      end
      S_EVCHK: begin
        if (64'(dt_q) > 64'(window_q) && held_q > CW'(1)) begin
          fdrop_d = 1'b0;
          state_d = S_DROP_RD;
        end else begin
          neg_d   = ws_q[twma_pkg::WS_W-1];
          num_d   = {ws_mag, twma_pkg::FRAC_W'(0)};
          den_d   = dt_q;
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_AVG_DIV;
        end
      end
      S_DROP_RD: begin
        mem_raddr = oldest_q;
        state_d   = S_DROP_MUL;
      end
      S_DROP_MUL: begin
        prod_d   = PW'(rd_val_q * $signed({1'b0, rd_dur_q}));
        dt_d     = dt_q - DTW'(rd_dur_q);
        oldest_d = oldest_inc;
        held_d   = held_q - CW'(1);
        state_d  = S_DROP_SUB;
      end
      S_DROP_SUB: begin
        ws_d    = ws_q - twma_pkg::WS_W'(prod_q);
        state_d = fdrop_q ? S_APPEND : S_EVCHK;
      end
      S_AVG_DIV: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        num_d = {num_q[NUM_W-2:0], 1'b0};
        cnt_d = cnt_q + KW'(1);
        if (div_last) begin
          avg_d   = neg_q ? twma_pkg::AVG_W'(-quo_nx) : quo_nx;
          state_d = S_PCT_INIT;
        end
      end
      S_PCT_INIT: begin
        if (held_q == '0) begin
          pct_d   = '0;
          state_d = S_DONE;
        end else begin
          idx_d   = newest_idx;
          hits_d  = '0;
          seen_d  = '0;
          span_d  = '0;
          state_d = S_PCT_RD;
        end
      end
      S_PCT_RD: begin
        mem_raddr = idx_q;
        state_d   = S_PCT_ACC;
      end
      S_PCT_ACC: begin
        span_d = span_n;
        hits_d = hits_n;
        seen_d = seen_n;
        if ((spancfg_q != '0 && 64'(span_n) >= 64'(spancfg_q)) || seen_n == held_q) begin
          num_d   = NUM_W'(hits_pct);
          den_d   = DTW'(seen_n);
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_PCT_DIV;
        end else begin
          idx_d   = idx_dec;
          state_d = S_PCT_RD;
        end
      end
      S_PCT_DIV: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        num_d = {num_q[NUM_W-2:0], 1'b0};
        cnt_d = cnt_q + KW'(1);
        if (div_last) begin
          pct_d   = quo_nx[twma_pkg::PCT_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, forced_q, taken_q, twma_pkg::CNT_W'(held_q), pct_q, avg_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Write and read the ring
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      val_mem[mem_waddr] <= val_q;
      dur_mem[mem_waddr] <= dur_q;
    end
    rd_val_q <= val_mem[mem_raddr];
    rd_dur_q <= dur_mem[mem_raddr];
  end

  // Hold control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oldest_q    <= '0;
      held_q      <= '0;
      ws_q        <= '0;
      dt_q        <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
      window_q    <= twma_pkg::WINDOW_RESET;
      thr_q       <= '0;
      spancfg_q   <= '0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      held_q      <= held_d;
      ws_q        <= ws_d;
      dt_q        <= dt_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          twma_pkg::CFG_WINDOW: window_q  <= cfg_data_i;
          twma_pkg::CFG_THRESH: thr_q     <= cfg_data_i;
          twma_pkg::CFG_SPAN:   spancfg_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Advance working registers
  always_ff @(posedge clk_i) begin
    idx_d_reg: begin
      idx_q      <= idx_d;
      hits_q     <= hits_d;
      seen_q     <= seen_d;
      span_q     <= span_d;
      prod_q     <= prod_d;
      val_q      <= val_d;
      dur_q      <= dur_d;
      taken_q    <= taken_d;
      forced_q   <= forced_d;
      fdrop_q    <= fdrop_d;
      neg_q      <= neg_d;
      rem_q      <= rem_d;
      den_q      <= den_d;
      num_q      <= num_d;
      quo_q      <= quo_d;
      cnt_q      <= cnt_d;
      pct_q      <= pct_d;
      out_data_q <= out_data_d;
    end
  end

endmodule

/* rtl/twma_checker.sv */
// Port-level checks for the moving average core, bound to its top level.
// Depends on twma_pkg and time_weighted_moving_average_core_defines.svh.
`timescale 1ns / 1ps
`include "time_weighted_moving_average_core_defines.svh"
module twma_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic [twma_pkg::PCT_W-1:0] pct;
  logic [twma_pkg::CNT_W-1:0] cnt;
  logic                       taken, forced;

  assign pct    = m_axis_tdata[twma_pkg::OUT_PCT_LSB +: twma_pkg::PCT_W];
  assign cnt    = m_axis_tdata[twma_pkg::OUT_CNT_LSB +: twma_pkg::CNT_W];
  assign taken  = m_axis_tdata[twma_pkg::OUT_TAKEN_BIT];
  assign forced = m_axis_tdata[twma_pkg::OUT_FORCED_BIT];

  // One request in work at a time
  `TWMA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  // Percentage never exceeds full scale
  `TWMA_ASSERT_NOW(a_pct_range, m_axis_tvalid, pct <= twma_pkg::PCT_W'(twma_pkg::PCT_SCALE), "percent above 100")
  // A taken sample leaves at least one entry
  `TWMA_ASSERT_NOW(a_taken_count, m_axis_tvalid && taken, cnt != '0, "taken with empty store")
  // A forced drop only comes with a taken sample
  `TWMA_ASSERT_NOW(a_forced_taken, m_axis_tvalid && forced, taken, "forced without taken")
  // A stalled result holds
  `TWMA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind time_weighted_moving_average_core twma_checker u_twma_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
